@@ design/gds_pkg.sv @@
// Package for the Gregorian date stepper.
// Holds command codes, calendar constants, the stage record and the month length function.
// No dependencies.
package gds_pkg;

  typedef enum logic [1:0] {
    CMD_CHECK = 2'd0,
    CMD_NEXT  = 2'd1,
    CMD_PREV  = 2'd2
  } cmd_e;

  localparam logic [3:0]  MONTH_JAN = 4'd1;
  localparam logic [3:0]  MONTH_FEB = 4'd2;
  localparam logic [3:0]  MONTH_DEC = 4'd12;
  localparam logic [4:0]  DAY_FIRST = 5'd1;
  localparam logic [4:0]  DAY_LONG  = 5'd31;
  localparam logic [4:0]  DAY_SHORT = 5'd30;
  localparam logic [4:0]  DAY_FEB_L = 5'd29;
  localparam logic [4:0]  DAY_FEB_N = 5'd28;
  localparam logic [15:0] YEAR_MIN  = 16'd1;
  localparam logic [15:0] YEAR_MAX  = 16'hFFFF;

  // Reciprocal of 25 scaled by 2^22, rounded up; exact quotient for 16-bit years.
  localparam int unsigned RECIP_SHIFT = 22;
  localparam logic [17:0] RECIP_25    = 18'd167773;
  localparam int unsigned QUOT_W      = 12;
  localparam logic [4:0]  DIV_25      = 5'd25;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [15:0] year;
    logic [4:0]  len;
    logic [4:0]  prev_len;
    logic        ok;
  } date_rec_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    len = 5'd0;
    if (m inside {4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12}) begin
      len = DAY_LONG;
    end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      len = DAY_SHORT;
    end else if (m == MONTH_FEB) begin
      len = leap ? DAY_FEB_L : DAY_FEB_N;
    end
    return len;
  endfunction

endpackage

@@ design/gregorian_date_step.sv @@
// Top level of the Gregorian date stepper: three-stage pipeline.
// Depends on gds_pkg and gds_step.
//
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+----------------------------------------
//  in       | in_valid_i   | in_stall_o   | command_i, month_i, day_i, year_i
//  out      | out_valid_o  | out_stall_i  | out_month_o, out_day_o, out_year_o,
//           |              |              | date_valid_o
//
// One item per cycle unless in_stall_o is high; a result passes the stage 1 and stage 2
// registers and then shows from the output register, where it can be taken.
// Stage 1 forms year/25 by a reciprocal multiply, stage 2 finds the leap year and
// month lengths, stage 3 steps the date into the output register.
// Reset clears the stage valid bits only.
// A stall on the output holds a full stage only when every stage after it is full; other stages still move and fill.
module gregorian_date_step (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [3:0]  month_i,
  input  logic [4:0]  day_i,
  input  logic [15:0] year_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  out_month_o,
  output logic [4:0]  out_day_o,
  output logic [15:0] out_year_o,
  output logic        date_valid_o
);
  import gds_pkg::*;

  logic en1, en2, en3;
  logic v1_q, v2_q, v3_q;

  logic [1:0]        cmd1_q;
  logic [3:0]        m1_q;
  logic [4:0]        d1_q;
  logic [15:0]       y1_q;
  logic [QUOT_W-1:0] q1_q;
  logic [33:0]       prod;

  date_rec_t rec2_d, rec2_q;
  logic [16:0] q_times_25;
  logic        div25, div100, div400, leap;

  logic [3:0]  m3_d, m3_q;
  logic [4:0]  d3_d, d3_q;
  logic [15:0] y3_d, y3_q;
  logic        ok3_d, ok3_q;

  assign en3        = !v3_q || !out_stall_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  assign prod = 34'(year_i) * 34'(RECIP_25);

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      cmd1_q <= command_i;
      m1_q   <= month_i;
      d1_q   <= day_i;
      y1_q   <= year_i;
      q1_q   <= prod[RECIP_SHIFT +: QUOT_W];
    end
  end

  assign q_times_25 = 17'(q1_q) * 17'(DIV_25);
  assign div25      = (q_times_25 == {1'b0, y1_q});
  assign div100     = div25 && (y1_q[1:0] == 2'b00);
  assign div400     = div25 && (y1_q[3:0] == 4'b0000);
  assign leap       = div400 || ((y1_q[1:0] == 2'b00) && !div100);

  always_comb begin
    rec2_d.cmd      = cmd1_q;
    rec2_d.month    = m1_q;
    rec2_d.day      = d1_q;
    rec2_d.year     = y1_q;
    rec2_d.len      = month_len(m1_q, leap);
    rec2_d.prev_len = month_len(m1_q - 4'd1, leap);
    rec2_d.ok       = (y1_q != 16'd0) && (rec2_d.len != 5'd0) &&
                      (d1_q != 5'd0) && (d1_q <= rec2_d.len);
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      rec2_q <= rec2_d;
    end
  end

  gds_step u_step (
    .rec_i   (rec2_q),
    .month_o (m3_d),
    .day_o   (d3_d),
    .year_o  (y3_d),
    .valid_o (ok3_d)
  );

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      m3_q  <= m3_d;
      d3_q  <= d3_d;
      y3_q  <= y3_d;
      ok3_q <= ok3_d;
    end
  end

  assign out_valid_o  = v3_q;
  assign out_month_o  = m3_q;
  assign out_day_o    = d3_q;
  assign out_year_o   = y3_q;
  assign date_valid_o = ok3_q;

endmodule

@@ design/gds_step.sv @@
// Day step logic for the Gregorian date stepper.
// Applies check, next day or previous day to a classified date record.
// Depends on gds_pkg.
module gds_step (
  input  gds_pkg::date_rec_t rec_i,
  output logic [3:0]         month_o,
  output logic [4:0]         day_o,
  output logic [15:0]        year_o,
  output logic               valid_o
);
  import gds_pkg::*;

  logic [3:0]  nm;
  logic [4:0]  nd;
  logic [15:0] ny;
  logic        ok;

  always_comb begin
    nm = rec_i.month;
    nd = rec_i.day;
    ny = rec_i.year;
    ok = rec_i.ok;
    case (rec_i.cmd)
      CMD_NEXT: begin
        if (rec_i.day < rec_i.len) begin
          nd = rec_i.day + DAY_FIRST;
        end else if (rec_i.month < MONTH_DEC) begin
          nd = DAY_FIRST;
          nm = rec_i.month + 4'd1;
        end else if (rec_i.year != YEAR_MAX) begin
          nd = DAY_FIRST;
          nm = MONTH_JAN;
          ny = rec_i.year + 16'd1;
        end else begin
          ok = 1'b0;
        end
      end
      CMD_PREV: begin
        if (rec_i.day > DAY_FIRST) begin
          nd = rec_i.day - DAY_FIRST;
        end else if (rec_i.month > MONTH_JAN) begin
          nm = rec_i.month - 4'd1;
          nd = rec_i.prev_len;
        end else if (rec_i.year > YEAR_MIN) begin
          nm = MONTH_DEC;
          nd = DAY_LONG;
          ny = rec_i.year - 16'd1;
        end else begin
          ok = 1'b0;
        end
      end
      default: begin
      end
    endcase
    if (!ok) begin
      nm = rec_i.month;
      nd = rec_i.day;
      ny = rec_i.year;
    end
  end

  assign month_o = nm;
  assign day_o   = nd;
  assign year_o  = ny;
  assign valid_o = ok;

endmodule

@@ design/gds_checker.sv @@
// Port-level checker for the Gregorian date stepper, bound to the top level.
// Depends on gregorian_date_step port names only.
module gds_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [3:0]  out_month_o,
  input logic [4:0]  out_day_o,
  input logic [15:0] out_year_o,
  input logic        date_valid_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_month_o) &&
      $stable(out_day_o) && $stable(out_year_o) && $stable(date_valid_o))
    else $error("stalled result item changed");

  a_valid_date: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && date_valid_o |-> out_month_o >= 4'd1 && out_month_o <= 4'd12 &&
      out_day_o != 5'd0 && out_year_o != 16'd0)
    else $error("valid result item holds an impossible date");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output is free");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result item shown during reset");

endmodule

bind gregorian_date_step gds_checker u_gds_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .out_month_o  (out_month_o),
  .out_day_o    (out_day_o),
  .out_year_o   (out_year_o),
  .date_valid_o (date_valid_o)
);
